>>> hw/rtl/imd5cd_pkg.sv
`default_nettype none
package imd5cd_pkg;

  // Request and result payloads.
  typedef struct packed {
    logic        kind;
    logic [59:0] imei_digits;
  } in_t;

  typedef struct packed {
    logic [25:0] code_value;
    logic        bad_digit;
  } out_t;

  // Working variables of the hash.
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } md5_st_t;

  // What moves from one round cell to the next.
  typedef struct packed {
    logic                bad;
    md5_st_t             st;
    logic [15:0][31:0]   w;
  } stage_t;

  localparam int unsigned NumRounds = 64;
  localparam logic [31:0] IvA = 32'h67452301;
  localparam logic [31:0] IvB = 32'hefcdab89;
  localparam logic [31:0] IvC = 32'h98badcfe;
  localparam logic [31:0] IvD = 32'h10325476;
  localparam logic [25:0] CodeMask = 26'h3FFFFFF;
  localparam logic [25:0] CodeSetBit = 26'h2000000;
  localparam logic [7:0]  MsgLen = 8'd31;

  localparam logic [31:0] MD5_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam logic [4:0] MD5_S [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  // Key strings, as ASCII bytes.
  localparam logic [7:0] KeyUnlock [14] = '{
    8'h68, 8'h77, 8'h65, 8'h36, 8'h32, 8'h30, 8'h64,
    8'h61, 8'h74, 8'h61, 8'h63, 8'h61, 8'h72, 8'h64
  };
  localparam logic [7:0] KeyFlash [11] = '{
    8'h65, 8'h36, 8'h33, 8'h30, 8'h75, 8'h70, 8'h67, 8'h72, 8'h61, 8'h64, 8'h65
  };

  // Index of the message word used in a given round.
  function automatic logic [3:0] md5_g(input logic [5:0] r);
    logic [3:0] g;
    unique case (r[5:4])
      2'd0: g = r[3:0];
      2'd1: g = 4'(r[3:0] * 4'd5 + 4'd1);
      2'd2: g = 4'(r[3:0] * 4'd3 + 4'd5);
      default: g = 4'(r[3:0] * 4'd7);
    endcase
    return g;
  endfunction

  // One round of the compression function.
  function automatic md5_st_t md5_round(input md5_st_t st, input logic [31:0] wg,
                                        input logic [5:0] r);
    logic [31:0] f;
    logic [31:0] sum;
    logic [4:0]  sh;
    md5_st_t     nx;
    unique case (r[5:4])
      2'd0: f = (st.b & st.c) | (~st.b & st.d);
      2'd1: f = (st.d & st.b) | (~st.d & st.c);
      2'd2: f = st.b ^ st.c ^ st.d;
      default: f = st.c ^ (st.b | ~st.d);
    endcase
    sh   = MD5_S[{r[5:4], r[1:0]}];
    sum  = st.a + f + MD5_K[r] + wg;
    nx.a = st.d;
    nx.d = st.c;
    nx.c = st.b;
    nx.b = st.b + ((sum << sh) | (sum >> (6'd32 - {1'b0, sh})));
    return nx;
  endfunction

  function automatic logic [7:0] hex_lower(input logic [3:0] v);
    return (v < 4'd10) ? (8'h30 + {4'h0, v}) : (8'h61 + {4'h0, v} - 8'd10);
  endfunction

  // Salt of a key string: hex characters 8 to 23 of its digest, char j in
  // bits 8j+7..8j. Evaluated only at elaboration.
  function automatic logic [127:0] key_salt(input logic kind);
    logic [7:0]  blk [64];
    logic [31:0] w [16];
    logic [31:0] h [4];
    logic [7:0]  dg;
    logic [127:0] s;
    md5_st_t     st;
    int          len;
    for (int i = 0; i < 64; i++) blk[i] = 8'h00;
    if (kind) begin
      len = 11;
      for (int i = 0; i < 11; i++) blk[i] = KeyFlash[i];
    end else begin
      len = 14;
      for (int i = 0; i < 14; i++) blk[i] = KeyUnlock[i];
    end
    blk[len] = 8'h80;
    blk[56] = 8'(len * 8);
    for (int i = 0; i < 16; i++) begin
      w[i] = {blk[4*i+3], blk[4*i+2], blk[4*i+1], blk[4*i]};
    end
    st = '{a: IvA, b: IvB, c: IvC, d: IvD};
    for (int r = 0; r < 64; r++) begin
      st = md5_round(st, w[md5_g(6'(r))], 6'(r));
    end
    h[0] = IvA + st.a;
    h[1] = IvB + st.b;
    h[2] = IvC + st.c;
    h[3] = IvD + st.d;
    s = '0;
    for (int i = 0; i < 8; i++) begin
      dg = h[(4 + i) / 4][8 * ((4 + i) % 4) +: 8];
      s[16*i +: 8]     = hex_lower(dg[7:4]);
      s[16*i + 8 +: 8] = hex_lower(dg[3:0]);
    end
    return s;
  endfunction

  localparam logic [127:0] SaltUnlock = key_salt(1'b0);
  localparam logic [127:0] SaltFlash  = key_salt(1'b1);

endpackage
`default_nettype wire

>>> hw/rtl/imei_md5_code_derive.sv
// IMEI code derivation engine.
// Input channel (in_valid_i / in_ready_o / in_i) takes one request: a kind
// selector and 15 BCD IMEI digits. Output channel (out_valid_o / out_ready_i /
// out_o) returns one result per request, in order: the 26-bit code and a flag
// that is set, with the code zero, when any digit nibble is above 9.
// The 64 hash rounds sit in a row of 64 round cells, one round per cell, so
// a request enters every cycle and a result leaves every cycle while the receiver keeps up.
// From acceptance to result valid a request passes the 64 round cells and then
// the output register, where the final addition and folding are done.
// The salts of both key strings are constants worked out at elaboration.
// When the receiver stalls, the whole row holds and in_ready_o falls;
// in_ready_o is high whenever the output register is empty or being taken.
// Reset clears all valid flags; no request is in flight afterwards and no
// clearing pass is needed.
`default_nettype none
module imei_md5_code_derive
  import imd5cd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_o
);

  logic   adv;
  logic   valid_s [NumRounds+1];
  stage_t stage_s [NumRounds+1];
  logic   out_valid_q;
  out_t   out_d, out_q;
  logic [31:0] fold;
  logic [31:0] swapped;

  // The row moves whenever the output register can take a result.
  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;
  assign valid_s[0] = in_valid_i;

  imd5cd_msg u_msg (
    .req_i  (in_i),
    .stage_o(stage_s[0])
  );

  for (genvar r = 0; r < NumRounds; r++) begin : g_cell
    imd5cd_cell #(
      .Round(6'(r))
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .valid_i(valid_s[r]),
      .stage_i(stage_s[r]),
      .valid_o(valid_s[r+1]),
      .stage_o(stage_s[r+1])
    );
  end

  // Final addition, byte-wise fold of the four digest words, byte reversal.
  always_comb begin
    fold = (IvA + stage_s[NumRounds].st.a) ^ (IvB + stage_s[NumRounds].st.b) ^
           (IvC + stage_s[NumRounds].st.c) ^ (IvD + stage_s[NumRounds].st.d);
    swapped = {fold[7:0], fold[15:8], fold[23:16], fold[31:24]};
    out_d.bad_digit  = stage_s[NumRounds].bad;
    out_d.code_value = stage_s[NumRounds].bad ? '0
                     : ((swapped[25:0] | CodeSetBit) & CodeMask);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= valid_s[NumRounds];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // A good result always carries the set bit; a flagged one carries zero.
  a_code_set : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_o.bad_digit) |-> out_o.code_value[25])
    else $error("code without bit 25 set");

  a_bad_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_o.bad_digit) |-> (out_o.code_value == '0))
    else $error("flagged result with non-zero code");

  // A stalled result is held, and the row does not move under it.
  a_stall_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_o) && !$past(in_ready_o)))
    else $error("result lost during stall");

endmodule
`default_nettype wire

>>> hw/rtl/imd5cd_msg.sv
`default_nettype none
module imd5cd_msg
  import imd5cd_pkg::*;
(
  input  in_t    req_i,
  output stage_t stage_o
);

  logic [7:0]   blk [64];
  logic [127:0] salt;
  logic         bad;

  // Form the padded 31-byte message: IMEI ASCII digits then the salt.
  always_comb begin
    salt = req_i.kind ? SaltFlash : SaltUnlock;
    bad  = 1'b0;
    for (int i = 0; i < 64; i++) blk[i] = 8'h00;
    for (int i = 0; i < 15; i++) begin
      blk[i] = {4'h3, req_i.imei_digits[4*(14-i) +: 4]};
      if (req_i.imei_digits[4*(14-i) +: 4] > 4'd9) bad = 1'b1;
    end
    for (int j = 0; j < 16; j++) blk[15+j] = salt[8*j +: 8];
    blk[31] = 8'h80;
    blk[56] = 8'(MsgLen * 8'd8);
  end

  // Pack little-endian message words and seed the hash state.
  always_comb begin
    stage_o.bad = bad;
    stage_o.st  = '{a: IvA, b: IvB, c: IvC, d: IvD};
    for (int i = 0; i < 16; i++) begin
      stage_o.w[i] = {blk[4*i+3], blk[4*i+2], blk[4*i+1], blk[4*i]};
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/imd5cd_cell.sv
`default_nettype none
module imd5cd_cell
  import imd5cd_pkg::*;
#(
  parameter logic [5:0] Round = 6'd0
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   en_i,
  input  logic   valid_i,
  input  stage_t stage_i,
  output logic   valid_o,
  output stage_t stage_o
);

  logic   valid_q;
  stage_t stage_d, stage_q;

  // One hash round; the message words ride along.
  always_comb begin
    stage_d    = stage_i;
    stage_d.st = md5_round(stage_i.st, stage_i.w[md5_g(Round)], Round);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule
`default_nettype wire

>>> bench/imei_md5_code_derive_tb.sv
`timescale 1ns / 100ps
`default_nettype none

module imei_md5_code_derive_tb;
  import imd5cd_pkg::*;

  localparam int unsigned Latency = 65;
  localparam int unsigned NumRandom = 1800;

  // Round constants and shift amounts of the hash.
  localparam logic [31:0] RoundK [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };
  localparam int RoundS [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

  // Digest of a short message (under 56 bytes), byte i of the digest at [8i+:8].
  function automatic logic [127:0] digest_of(input logic [7:0] msg [], input int len);
    logic [7:0]  blk [64];
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, f, t, sum;
    logic [127:0] dg;
    int g, sh;
    for (int i = 0; i < 64; i++) blk[i] = (i < len) ? msg[i] : 8'h00;
    blk[len] = 8'h80;
    for (int i = 0; i < 8; i++) blk[56 + i] = 8'((64'(len) * 8) >> (8 * i));
    for (int i = 0; i < 16; i++) w[i] = {blk[4*i+3], blk[4*i+2], blk[4*i+1], blk[4*i]};
    a = 32'h67452301; b = 32'hefcdab89; c = 32'h98badcfe; d = 32'h10325476;
    for (int i = 0; i < 64; i++) begin
      if (i < 16) begin
        f = (b & c) | (~b & d); g = i;
      end else if (i < 32) begin
        f = (d & b) | (~d & c); g = (5 * i + 1) % 16;
      end else if (i < 48) begin
        f = b ^ c ^ d; g = (3 * i + 5) % 16;
      end else begin
        f = c ^ (b | ~d); g = (7 * i) % 16;
      end
      sh = RoundS[(i / 16) * 4 + (i % 4)];
      sum = a + f + RoundK[i] + w[g];
      t = d; d = c; c = b;
      b = b + ((sum << sh) | (sum >> (32 - sh)));
      a = t;
    end
    dg = {32'h10325476 + d, 32'h98badcfe + c, 32'hefcdab89 + b, 32'h67452301 + a};
    return dg;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    return (v < 4'd10) ? 8'h30 + 8'(v) : 8'h61 + 8'(v) - 8'd10;
  endfunction

  // Works out the code for one IMEI request.
  function automatic out_t derive_code(input in_t req);
    logic [7:0] key [];
    logic [7:0] msg [];
    logic [127:0] dg;
    logic [3:0] nib;
    logic [31:0] word;
    out_t res;
    msg = new[31];
    res = '0;
    for (int i = 0; i < 15; i++) begin
      nib = req.imei_digits[4 * (14 - i) +: 4];
      if (nib > 4'd9) res.bad_digit = 1'b1;
      msg[i] = 8'h30 + 8'(nib);
    end
    if (res.bad_digit) return res;
    if (req.kind)
      key = {8'h65, 8'h36, 8'h33, 8'h30, 8'h75, 8'h70, 8'h67, 8'h72, 8'h61, 8'h64, 8'h65};
    else
      key = {8'h68, 8'h77, 8'h65, 8'h36, 8'h32, 8'h30, 8'h64, 8'h61, 8'h74, 8'h61,
             8'h63, 8'h61, 8'h72, 8'h64};
    dg = digest_of(key, key.size());
    // The salt is hex characters 8 to 23, i.e. digest bytes 4 to 11.
    for (int i = 0; i < 8; i++) begin
      msg[15 + 2 * i] = hex_char(dg[8 * (4 + i) + 4 +: 4]);
      msg[16 + 2 * i] = hex_char(dg[8 * (4 + i) +: 4]);
    end
    dg = digest_of(msg, 31);
    word = '0;
    for (int i = 0; i < 4; i++) begin
      word[8 * (3 - i) +: 8] = dg[8*i +: 8] ^ dg[8*(i+4) +: 8] ^ dg[8*(i+8) +: 8]
                             ^ dg[8*(i+12) +: 8];
    end
    res.code_value = 26'(word) | 26'h2000000;
    return res;
  endfunction

  // Holds the codes still owed by the block, oldest first.
  class code_scoreboard;
    out_t pending_codes [$];
    int   errors;

    function void note_request(input in_t req);
      pending_codes.push_back(derive_code(req));
    endfunction

    function void check_result(input out_t got);
      out_t exp_res;
      if (pending_codes.size() == 0) begin
        $error("unexpected result code_value=%h bad_digit=%b", got.code_value, got.bad_digit);
        errors++;
        return;
      end
      exp_res = pending_codes.pop_front();
      if (got.code_value !== exp_res.code_value) begin
        $error("code_value: expected %h, got %h", exp_res.code_value, got.code_value);
        errors++;
      end
      if (got.bad_digit !== exp_res.bad_digit) begin
        $error("bad_digit: expected %b, got %b", exp_res.bad_digit, got.bad_digit);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  in_t  in_i;
  logic out_valid_o;
  logic out_ready_i;
  out_t out_o;

  code_scoreboard board;
  bit quiet_phase;
  bit hold_receiver;
  bit sender_done;

  imei_md5_code_derive uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_o      (out_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Random IMEI digits, all valid BCD.
  function automatic logic [59:0] good_imei();
    logic [59:0] v;
    for (int i = 0; i < 15; i++) v[4*i +: 4] = 4'($urandom_range(0, 9));
    return v;
  endfunction

  // Offers one request and waits until it is taken.
  task automatic send_request(input logic kind, input logic [59:0] digits);
    in_valid_i <= 1'b1;
    in_i <= '{kind: kind, imei_digits: digits};
    do @(posedge clk_i); while (!in_ready_o);
    board.note_request('{kind: kind, imei_digits: digits});
  endtask

  // Drops valid for a random burst, sometimes.
  task automatic sender_gap();
    if (!quiet_phase && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (board.pending_codes.size() != 0) @(posedge clk_i);
  endtask

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_receiver) begin
        out_ready_i <= 1'b0;
        repeat (300) @(posedge clk_i);
        hold_receiver = 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // Result checking at each taken result.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) board.check_result(out_o);
  end

  // Main stimulus.
  initial begin
    logic [59:0] v;
    board = new();
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    in_i <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: digit extremes, both kinds, a bad nibble at every even position.
    for (int k = 0; k < 2; k++) begin
      send_request(k[0], 60'h0);
      send_request(k[0], {15{4'h9}});
      send_request(k[0], 60'h123456789012345);
      send_request(k[0], {15{4'hF}});
      send_request(k[0], {4'hA, 56'h0});
      send_request(k[0], {56'h0, 4'hA});
    end
    for (int p = 0; p < 8; p++) begin
      v = good_imei();
      v[4 * (2 * p) +: 4] = 4'hA + 4'(p % 6);
      send_request(p[0], v);
    end
    // Sender pause until every code is back.
    wait_drained();

    // Random part: mostly valid IMEIs, some with stray nibbles.
    for (int n = 0; n < NumRandom; n++) begin
      if (n == 600) hold_receiver = 1'b1;
      if (n == 1200) wait_drained();
      if (n == 1500) quiet_phase = 1'b1;
      if ($urandom_range(0, 9) == 0) v = 60'({$urandom, $urandom});
      else v = good_imei();
      send_request(1'($urandom_range(0, 1)), v);
      sender_gap();
    end
    in_valid_i <= 1'b0;

    while (board.pending_codes.size() != 0) @(posedge clk_i);
    repeat (Latency + 10) @(posedge clk_i);
    if (board.errors == 0) $display("** imei_md5_code_derive: PASSED **");
    else $display("** imei_md5_code_derive: FAILED **");
    $finish;
  end

  // Watchdog.
  initial begin
    #2000000;
    $display("** imei_md5_code_derive: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire
